>>> src/sso_pkg.sv
`default_nettype none
package sso_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_OVERLOAD_TOP    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERLOAD_BOTTOM = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_TOP        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_BOTTOM     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMBINE         = 3'd4;

  localparam logic signed [15:0] MIN_RESET = 16'sh7FFF;
  localparam logic signed [15:0] MAX_RESET = 16'sh8000;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ZONE_NORMAL = 3'd0,
    ZONE_PHIGH  = 3'd1,
    ZONE_POVER  = 3'd2,
    ZONE_NHIGH  = 3'd3,
    ZONE_NOVER  = 3'd4
  } zone_t;

  typedef struct packed {
    logic signed [15:0] overload_top;
    logic signed [15:0] overload_bottom;
    logic signed [15:0] high_top;
    logic signed [15:0] high_bottom;
    logic               combine;
  } cfg_t;

  typedef struct packed {
    logic               start_req;
    logic [2:0]         channel;
    logic signed [15:0] sample;
    logic [31:0]        square;
    zone_t              zone;
    logic               combine;
  } entry_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic [31:0]        count;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic [31:0]        overloads;
    logic [31:0]        runs;
    logic [31:0]        anomalies;
    logic signed [47:0] sum;
    logic [61:0]        sum_squares;
    zone_t              zone;
    logic               saturated;
  } result_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

>>> src/sso_in_if.sv
`default_nettype none
interface sso_in_if;
  logic               valid;
  logic               ready;
  logic               start_req;
  logic [2:0]         channel;
  logic signed [15:0] sample;

  modport source (output valid, start_req, channel, sample, input ready);
  modport sink (input valid, start_req, channel, sample, output ready);
endinterface
`default_nettype wire

>>> src/sso_out_if.sv
`default_nettype none
interface sso_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic [31:0]        count;
  logic signed [15:0] minimum;
  logic signed [15:0] maximum;
  logic [31:0]        overloads;
  logic [31:0]        runs;
  logic [31:0]        anomalies;
  logic signed [47:0] sum;
  logic [61:0]        sum_squares;
  logic [2:0]         zone;
  logic               saturated;

  modport source (output valid, out_channel, count, minimum, maximum, overloads, runs,
                  anomalies, sum, sum_squares, zone, saturated, input ready);
  modport sink (input valid, out_channel, count, minimum, maximum, overloads, runs,
                anomalies, sum, sum_squares, zone, saturated, output ready);
endinterface
`default_nettype wire

>>> src/sso_front.sv
`default_nettype none
module sso_front
  import sso_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  cfg_t         cfg,
  sso_in_if.sink       in_if,
  output entry_t       ent,
  output logic         push,
  input  logic         q_ready
);

  localparam logic [8:0] NCH = 9'(MAX_CHANNELS);

  logic [8:0]         ch_v;
  logic signed [15:0] up;
  logic signed [15:0] lw;
  logic signed [31:0] sq_full;
  zone_t              zone;

  always_comb begin
    ch_v = {6'd0, in_if.channel};
    for (int i = 0; i < 7; i++) begin
      if (ch_v >= NCH) begin
        ch_v = ch_v - NCH;
      end
    end
  end

  always_comb begin
    up = cfg.combine ? cfg.overload_top : cfg.high_top;
    lw = cfg.combine ? cfg.overload_bottom : cfg.high_bottom;
    if (in_if.sample >= up) begin
      zone = (in_if.sample >= cfg.overload_top) ? ZONE_POVER : ZONE_PHIGH;
    end else if (in_if.sample <= lw) begin
      zone = (in_if.sample <= cfg.overload_bottom) ? ZONE_NOVER : ZONE_NHIGH;
    end else begin
      zone = ZONE_NORMAL;
    end
  end

  assign sq_full = in_if.sample * in_if.sample;

  assign ent.start_req = in_if.start_req;
  assign ent.channel   = ch_v[2:0];
  assign ent.sample    = in_if.sample;
  assign ent.square    = $unsigned(sq_full);
  assign ent.zone      = zone;
  assign ent.combine   = cfg.combine;

  assign push        = in_if.valid;
  assign in_if.ready = q_ready;

endmodule
`default_nettype wire

>>> src/sso_queue.sv
`default_nettype none
module sso_queue
  import sso_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   push_ready,
  input  logic   pop,
  output entry_t pop_data,
  output logic   pop_valid
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> src/sso_back.sv
`default_nettype none
module sso_back
  import sso_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  input  entry_t ent,
  input  logic   ent_valid,
  output logic   ent_pop,
  sso_out_if.source out_if
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [31:0]        count_r    [MAX_CHANNELS];
  logic signed [15:0] min_r      [MAX_CHANNELS];
  logic signed [15:0] max_r      [MAX_CHANNELS];
  logic [31:0]        overload_r [MAX_CHANNELS];
  logic [31:0]        run_r      [MAX_CHANNELS];
  logic [31:0]        anomaly_r  [MAX_CHANNELS];
  logic signed [47:0] sum_r      [MAX_CHANNELS];
  logic [61:0]        square_r   [MAX_CHANNELS];
  zone_t              zone_r     [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] valid_r, valid_nxt;

  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   idx;
  logic               take;
  logic               live;
  result_t            cur;
  logic               sat;
  logic               ovl;
  logic               anom;

  assign idx     = IDX_W'(ent.channel);
  assign take    = ent_valid && (!out_valid_r || out_if.ready);
  assign ent_pop = take;
  assign live    = valid_r[idx] && !ent.start_req;

  always_comb begin
    cur.out_channel = ent.channel;
    cur.saturated   = 1'b0;
    if (live) begin
      cur.count       = count_r[idx];
      cur.minimum     = min_r[idx];
      cur.maximum     = max_r[idx];
      cur.overloads   = overload_r[idx];
      cur.runs        = run_r[idx];
      cur.anomalies   = anomaly_r[idx];
      cur.sum         = sum_r[idx];
      cur.sum_squares = square_r[idx];
      cur.zone        = zone_r[idx];
    end else begin
      cur.count       = '0;
      cur.minimum     = MIN_RESET;
      cur.maximum     = MAX_RESET;
      cur.overloads   = '0;
      cur.runs        = '0;
      cur.anomalies   = '0;
      cur.sum         = '0;
      cur.sum_squares = '0;
      cur.zone        = ZONE_NORMAL;
    end
  end

  always_comb begin
    sat  = (cur.count == CNT_MAX);
    ovl  = (ent.zone == ZONE_POVER) || (ent.zone == ZONE_NOVER);
    anom = ((ent.zone inside {ZONE_PHIGH, ZONE_POVER}) &&
            (cur.zone inside {ZONE_NHIGH, ZONE_NOVER})) ||
           ((ent.zone == ZONE_NOVER) && (cur.zone inside {ZONE_PHIGH, ZONE_POVER})) ||
           ((ent.zone == ZONE_NHIGH) && (cur.zone == ZONE_PHIGH));
    res_nxt = cur;
    res_nxt.saturated = sat;
    if (!sat) begin
      res_nxt.count = cur.count + 32'd1;
      if (ent.sample < cur.minimum) begin
        res_nxt.minimum = ent.sample;
      end
      if (ent.sample > cur.maximum) begin
        res_nxt.maximum = ent.sample;
      end
      if (ovl) begin
        res_nxt.overloads = sat_inc(cur.overloads);
      end
      if (ovl && (cur.zone != ent.zone)) begin
        res_nxt.runs = sat_inc(cur.runs);
      end
      if (anom) begin
        res_nxt.anomalies = sat_inc(cur.anomalies);
      end
      res_nxt.zone        = ent.zone;
      res_nxt.sum         = cur.sum + 48'(ent.sample);
      res_nxt.sum_squares = cur.sum_squares + {30'd0, ent.square};
    end
    if (ent.combine) begin
      res_nxt.runs      = '0;
      res_nxt.anomalies = '0;
    end
  end

  always_comb begin
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      valid_nxt[idx] = 1'b1;
      out_valid_nxt  = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r           <= res_nxt;
      count_r[idx]    <= res_nxt.count;
      min_r[idx]      <= res_nxt.minimum;
      max_r[idx]      <= res_nxt.maximum;
      overload_r[idx] <= res_nxt.overloads;
      run_r[idx]      <= res_nxt.runs;
      anomaly_r[idx]  <= res_nxt.anomalies;
      sum_r[idx]      <= res_nxt.sum;
      square_r[idx]   <= res_nxt.sum_squares;
      zone_r[idx]     <= res_nxt.zone;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_channel = res_r.out_channel;
  assign out_if.count       = res_r.count;
  assign out_if.minimum     = res_r.minimum;
  assign out_if.maximum     = res_r.maximum;
  assign out_if.overloads   = res_r.overloads;
  assign out_if.runs        = res_r.runs;
  assign out_if.anomalies   = res_r.anomalies;
  assign out_if.sum         = res_r.sum;
  assign out_if.sum_squares = res_r.sum_squares;
  assign out_if.zone        = res_r.zone;
  assign out_if.saturated   = res_r.saturated;

endmodule
`default_nettype wire

>>> src/sample_statistics_overload_unit.sv
`default_nettype none
// An accepted word is stored in the queue, then registered by the update stage at the output.
// One word per cycle unless the output stalls; per-channel statistics update as entries are taken.
// A two-entry queue between classifier and update stage absorbs output stalls.
// Reset (synchronous, active low) marks every channel as cleared and loads the
// threshold registers with their defaults; no clearing pass is needed.
module sample_statistics_overload_unit
  import sso_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sso_in_if.sink                     in_if,
  sso_out_if.source                  out_if
);

  cfg_t   cfg_r, cfg_nxt;
  entry_t f_ent;
  logic   f_push;
  logic   q_ready;
  entry_t q_ent;
  logic   q_valid;
  logic   q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_OVERLOAD_TOP:    cfg_nxt.overload_top    = $signed(cfg_data);
        CFG_OVERLOAD_BOTTOM: cfg_nxt.overload_bottom = $signed(cfg_data);
        CFG_HIGH_TOP:        cfg_nxt.high_top        = $signed(cfg_data);
        CFG_HIGH_BOTTOM:     cfg_nxt.high_bottom     = $signed(cfg_data);
        CFG_COMBINE:         cfg_nxt.combine         = cfg_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overload_top    <= 16'sh7FFF;
      cfg_r.overload_bottom <= 16'sh8000;
      cfg_r.high_top        <= 16'sh4000;
      cfg_r.high_bottom     <= -16'sh4000;
      cfg_r.combine         <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sso_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .cfg     (cfg_r),
    .in_if   (in_if),
    .ent     (f_ent),
    .push    (f_push),
    .q_ready (q_ready)
  );

  sso_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  (f_ent),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_ent),
    .pop_valid  (q_valid)
  );

  sso_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent       (q_ent),
    .ent_valid (q_valid),
    .ent_pop   (q_pop),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire
